[rtl/dnle_pkg.sv]
package dnle_pkg;

  // Default limits
  localparam int MAX_LABEL_DEF = 63;
  localparam int MAX_NAME_DEF  = 255;

  // Widths fixed by the item fields
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 6;
  localparam int ENC_W  = 8;
  localparam int TOT_W  = 9;
  localparam int POS_W  = 7;
  localparam int BC_W   = 2;
  localparam int STS_W  = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_DOT = 8'd46;
  localparam logic [CHAR_W-1:0] CH_END = 8'd0;

  // Result status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_LABEL = 2'd1;
  localparam logic [STS_W-1:0] ST_NAME  = 2'd2;

  // Byte count codes
  localparam logic [BC_W-1:0] BC_NONE = 2'd0;
  localparam logic [BC_W-1:0] BC_ONE  = 2'd1;
  localparam logic [BC_W-1:0] BC_TWO  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_data;
    logic load_err;
  } dp_cmd_t;

  typedef struct packed {
    logic start_flush;
    logic start_err;
    logic more;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/dnle_ctrl.sv]
module dnle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output dnle_pkg::dp_cmd_t    cmd,
  input  dnle_pkg::dp_status_t dp_st
);

  dnle_pkg::state_t state;
  dnle_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dnle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence intake, label readout and error beats
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      dnle_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (dp_st.start_flush) begin
            state_next = dnle_pkg::S_READ;
          end else if (dp_st.start_err) begin
            state_next = dnle_pkg::S_ERR;
          end
        end
      end
      dnle_pkg::S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = dnle_pkg::S_EMIT;
      end
      dnle_pkg::S_EMIT: begin
        if (dp_st.out_free) begin
          cmd.load_data = 1'b1;
          if (dp_st.more) begin
            cmd.rd_en = 1'b1;
          end else begin
            state_next = dnle_pkg::S_IDLE;
          end
        end
      end
      dnle_pkg::S_ERR: begin
        if (dp_st.out_free) begin
          cmd.load_err = 1'b1;
          state_next   = dnle_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dnle_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/dnle_datapath.sv]
module dnle_datapath #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
  parameter int MAX_NAME  = dnle_pkg::MAX_NAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dnle_pkg::CHAR_W-1:0]   char_in,
  input  dnle_pkg::dp_cmd_t             cmd,
  output dnle_pkg::dp_status_t          dp_st,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dnle_pkg::CHAR_W-1:0]   first_byte,
  output logic [dnle_pkg::CHAR_W-1:0]   second_byte,
  output logic [dnle_pkg::BC_W-1:0]     byte_count,
  output logic [dnle_pkg::STS_W-1:0]    status,
  output logic                          last
);

  localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int CW     = dnle_pkg::CNT_W;
  localparam int PW     = dnle_pkg::POS_W;
  localparam int TW     = dnle_pkg::TOT_W;

  logic [dnle_pkg::CHAR_W-1:0] mem [MAX_LABEL];

  logic [CW-1:0]                label_count;
  logic [dnle_pkg::ENC_W-1:0]   encoded_count;
  logic                         dropping;
  logic [CW-1:0]                fl_n;
  logic [PW-1:0]                fl_len;
  logic [PW-1:0]                pos;
  logic [PW-1:0]                pos_r;
  logic [dnle_pkg::CHAR_W-1:0]  rd_a;
  logic [dnle_pkg::CHAR_W-1:0]  rd_b;
  logic [dnle_pkg::STS_W-1:0]   err_code;

  logic                         is_end;
  logic                         is_dot;
  logic [TW-1:0]                total;
  logic                         name_over;
  logic                         label_full;
  logic                         has_label;
  logic                         do_write;
  logic [ADDR_W-1:0]            addr_a;
  logic [ADDR_W-1:0]            addr_b;
  logic [PW-1:0]                fl_nx;
  logic [PW-1:0]                pos_r1;
  logic [PW-1:0]                pos_r2;
  logic                         two;
  logic [dnle_pkg::CHAR_W-1:0]  byte_a;
  logic [dnle_pkg::CHAR_W-1:0]  byte_b;

  // Classify the incoming character against the current label and name
  always_comb begin
    is_end     = (char_in == dnle_pkg::CH_END);
    is_dot     = (char_in == dnle_pkg::CH_DOT);
    total      = TW'(encoded_count) + TW'(label_count) + TW'(1);
    name_over  = (total > TW'(MAX_NAME));
    label_full = (label_count >= CW'(MAX_LABEL));
    has_label  = (label_count != '0);
    do_write   = cmd.accept && !is_end && !is_dot && !dropping && !label_full;
    if (is_end) begin
      dp_st.start_flush = !dropping && !(has_label && name_over);
      dp_st.start_err   = !dropping && has_label && name_over;
    end else begin
      dp_st.start_flush = !dropping && is_dot && !name_over;
      dp_st.start_err   = !dropping && (is_dot ? name_over : label_full);
    end
    dp_st.more     = (pos < fl_len);
    dp_st.out_free = !out_valid || !out_stall;
  end

  // Track label length, encoded length and the drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      label_count   <= '0;
      encoded_count <= '0;
      dropping      <= 1'b0;
    end else if (cmd.accept) begin
      if (is_end) begin
        label_count   <= '0;
        encoded_count <= '0;
        dropping      <= 1'b0;
      end else if (!dropping) begin
        if (is_dot) begin
          if (name_over) begin
            dropping <= 1'b1;
          end else begin
            label_count   <= '0;
            encoded_count <= total[dnle_pkg::ENC_W-1:0];
          end
        end else if (label_full) begin
          dropping <= 1'b1;
        end else begin
          label_count <= label_count + CW'(1);
        end
      end
    end
  end

  // Capture the flush length on intake; advance the byte position per read
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.accept) begin
      pos <= '0;
    end else if (cmd.rd_en) begin
      pos <= pos + PW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fl_n     <= label_count;
      err_code <= (is_end || is_dot) ? dnle_pkg::ST_NAME : dnle_pkg::ST_LABEL;
      if (is_end) begin
        fl_len <= has_label ? (PW'(label_count) + PW'(2)) : PW'(1);
      end else begin
        fl_len <= PW'(label_count) + PW'(1);
      end
    end
  end

  // Label buffer: one write port, two registered read ports
  assign addr_a = ADDR_W'(pos - PW'(1));
  assign addr_b = pos[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[label_count[ADDR_W-1:0]] <= char_in;
    end
    if (cmd.rd_en) begin
      rd_a  <= mem[addr_a];
      rd_b  <= mem[addr_b];
      pos_r <= pos;
    end
  end

  // Pick length byte, label byte or terminator for each half of the beat
  always_comb begin
    fl_nx  = PW'(fl_n);
    pos_r1 = pos_r + PW'(1);
    pos_r2 = pos_r + PW'(2);
    two    = (pos_r1 < fl_len);
    if (pos_r == '0) begin
      byte_a = dnle_pkg::CHAR_W'(fl_n);
    end else if (pos_r <= fl_nx) begin
      byte_a = rd_a;
    end else begin
      byte_a = '0;
    end
    byte_b = (two && (pos_r1 <= fl_nx)) ? rd_b : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_data || cmd.load_err) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_data) begin
      first_byte  <= byte_a;
      second_byte <= byte_b;
      byte_count  <= two ? dnle_pkg::BC_TWO : dnle_pkg::BC_ONE;
      status      <= dnle_pkg::ST_OK;
      last        <= (pos_r2 >= fl_len);
    end else if (cmd.load_err) begin
      first_byte  <= '0;
      second_byte <= '0;
      byte_count  <= dnle_pkg::BC_NONE;
      status      <= err_code;
      last        <= 1'b1;
    end
  end

endmodule

[rtl/dns_name_label_encoder.sv]
// Channel  | Handshake            | Beat contents
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_stall  | char_in
// output   | out_valid / out_stall| first_byte, second_byte, byte_count, status, last
//
// A label character, or any character while dropping, is only stored or skipped; an error also emits an error beat.
// A '.' with a label of n characters runs intake, a buffer read, then one beat per cycle
// from the two-port label buffer while out_stall is low, ceil((n + 1) / 2) beats in all.
// The end byte does the same with ceil((n + 2) / 2) beats with a label, one beat without.
// Reset clears the counters and the drop flag; the label buffer keeps its contents.
// out_stall holds the output register and the readout; in_stall is high meanwhile.
module dns_name_label_encoder #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
  parameter int MAX_NAME  = dnle_pkg::MAX_NAME_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dnle_pkg::CHAR_W-1:0] char_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dnle_pkg::CHAR_W-1:0] first_byte,
  output logic [dnle_pkg::CHAR_W-1:0] second_byte,
  output logic [dnle_pkg::BC_W-1:0]   byte_count,
  output logic [dnle_pkg::STS_W-1:0]  status,
  output logic                        last
);

  dnle_pkg::dp_cmd_t    cmd;
  dnle_pkg::dp_status_t dp_st;

  dnle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .dp_st    (dp_st)
  );

  dnle_datapath #(
    .MAX_LABEL (MAX_LABEL),
    .MAX_NAME  (MAX_NAME)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .char_in     (char_in),
    .cmd         (cmd),
    .dp_st       (dp_st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .byte_count  (byte_count),
    .status      (status),
    .last        (last)
  );

endmodule

[rtl/dnle_chk.sv]
module dnle_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [dnle_pkg::CHAR_W-1:0] char_in,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [dnle_pkg::CHAR_W-1:0] first_byte,
  input logic [dnle_pkg::CHAR_W-1:0] second_byte,
  input logic [dnle_pkg::BC_W-1:0]   byte_count,
  input logic [dnle_pkg::STS_W-1:0]  status,
  input logic                        last
);

  // No beat is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat offered right after reset");

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(first_byte) &&
      $stable(second_byte) && $stable(byte_count) && $stable(status) && $stable(last))
    else $error("stalled output beat changed");

  // An error beat carries no bytes and ends the item
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dnle_pkg::ST_OK |->
      byte_count == dnle_pkg::BC_NONE && first_byte == '0 && second_byte == '0 && last)
    else $error("malformed error beat");

  // An empty beat is only an error beat
  a_none_is_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == dnle_pkg::BC_NONE |->
      (status == dnle_pkg::ST_LABEL || status == dnle_pkg::ST_NAME))
    else $error("empty beat without error status");

  // A single byte beat closes the stream with a zero pad
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == dnle_pkg::BC_ONE |-> last && second_byte == '0)
    else $error("single byte beat not last or not padded");

endmodule

bind dns_name_label_encoder dnle_chk u_chk (.*);

[dv/dns_name_label_encoder_tb.sv]
`timescale 1ns / 100ps

module dns_name_label_encoder_tb;

  localparam int MAX_LABEL    = dnle_pkg::MAX_LABEL_DEF;
  localparam int MAX_NAME     = dnle_pkg::MAX_NAME_DEF;
  localparam int RANDOM_ITEMS = 80;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [dnle_pkg::CHAR_W-1:0] b0;
    logic [dnle_pkg::CHAR_W-1:0] b1;
    logic [dnle_pkg::BC_W-1:0]   cnt;
    logic [dnle_pkg::STS_W-1:0]  sts;
    logic                        lst;
  } wire_beat_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [dnle_pkg::CHAR_W-1:0] char_in;
  logic                        out_valid;
  logic                        out_stall;
  logic [dnle_pkg::CHAR_W-1:0] first_byte;
  logic [dnle_pkg::CHAR_W-1:0] second_byte;
  logic [dnle_pkg::BC_W-1:0]   byte_count;
  logic [dnle_pkg::STS_W-1:0]  status;
  logic                        last;

  // Encoder shadow state
  logic [dnle_pkg::CHAR_W-1:0] label_buf [MAX_LABEL];
  int unsigned                 lbl_fill;
  int unsigned                 name_len;
  bit                          discard;
  logic [dnle_pkg::CHAR_W-1:0] flush_bytes [$];
  wire_beat_t                  wire_q [$];

  bit          calm;
  int          chars_sent;
  int          mismatch_cnt;
  int          stall_left;
  longint      cycle_cnt;

  dns_name_label_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .first_byte (first_byte),
    .second_byte(second_byte),
    .byte_count (byte_count),
    .status     (status),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none during a calm stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [dnle_pkg::CHAR_W-1:0] label_char();
    logic [dnle_pkg::CHAR_W-1:0] c;
    do c = dnle_pkg::CHAR_W'($urandom_range(1, 255)); while (c == dnle_pkg::CH_DOT);
    return c;
  endfunction

  function void push_error(logic [dnle_pkg::STS_W-1:0] code);
    wire_beat_t e;
    e.b0  = '0;
    e.b1  = '0;
    e.cnt = dnle_pkg::BC_NONE;
    e.sts = code;
    e.lst = 1'b1;
    wire_q.push_back(e);
    discard = 1'b1;
  endfunction

  // Append length byte and label; refuse when the name would overflow
  function bit append_label();
    if (name_len + 1 + lbl_fill > MAX_NAME) return 1'b0;
    flush_bytes.push_back(dnle_pkg::CHAR_W'(lbl_fill));
    for (int i = 0; i < lbl_fill; i++) flush_bytes.push_back(label_buf[i]);
    name_len = name_len + 1 + lbl_fill;
    lbl_fill = 0;
    return 1'b1;
  endfunction

  // Pack the flushed bytes two per beat
  function void pack_wire_bytes();
    wire_beat_t e;
    for (int p = 0; p < flush_bytes.size(); p += 2) begin
      e.b0  = flush_bytes[p];
      e.b1  = (p + 1 < flush_bytes.size()) ? flush_bytes[p+1] : '0;
      e.cnt = (p + 1 < flush_bytes.size()) ? dnle_pkg::BC_TWO : dnle_pkg::BC_ONE;
      e.sts = dnle_pkg::ST_OK;
      e.lst = (p + 2 >= flush_bytes.size());
      wire_q.push_back(e);
    end
  endfunction

  function void encode_char(logic [dnle_pkg::CHAR_W-1:0] c);
    flush_bytes.delete();
    if (c == dnle_pkg::CH_END) begin
      if (!discard) begin
        if (lbl_fill != 0 && !append_label()) begin
          push_error(dnle_pkg::ST_NAME);
        end else begin
          flush_bytes.push_back(8'h00);
          pack_wire_bytes();
        end
      end
      lbl_fill = 0;
      name_len = 0;
      discard  = 1'b0;
    end else if (!discard) begin
      if (c == dnle_pkg::CH_DOT) begin
        if (append_label()) pack_wire_bytes();
        else push_error(dnle_pkg::ST_NAME);
      end else if (lbl_fill >= MAX_LABEL) begin
        push_error(dnle_pkg::ST_LABEL);
      end else begin
        label_buf[lbl_fill] = c;
        lbl_fill++;
      end
    end
  endfunction

  // Send one character beat and predict its results on acceptance
  task automatic send_char(input logic [dnle_pkg::CHAR_W-1:0] c);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_char(c);
    chars_sent++;
  endtask

  task automatic send_label(input int len);
    for (int i = 0; i < len; i++) send_char(label_char());
  endtask

  // Three full labels: 192 encoded bytes
  task automatic send_long_prefix();
    repeat (3) begin
      send_label(MAX_LABEL);
      send_char(dnle_pkg::CH_DOT);
    end
  endtask

  task automatic test_short_names();
    // empty name, root only
    send_char(dnle_pkg::CH_END);
    send_char(dnle_pkg::CH_DOT);
    send_char(dnle_pkg::CH_END);
    // byte extremes, empty label in the middle, odd final label
    send_char(8'h01);
    send_char(8'hFF);
    send_char(dnle_pkg::CH_DOT);
    send_char(8'h2D);
    send_char(dnle_pkg::CH_DOT);
    send_char(dnle_pkg::CH_DOT);
    send_char(8'h2F);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(dnle_pkg::CH_END);
    // trailing dot leaves only the terminator
    send_char(8'h61);
    send_char(8'h62);
    send_char(dnle_pkg::CH_DOT);
    send_char(dnle_pkg::CH_END);
    // even final label
    send_char(8'h78);
    send_char(8'h79);
    send_char(8'h7A);
    send_char(8'h77);
    send_char(dnle_pkg::CH_END);
  endtask

  task automatic test_label_limit();
    calm = 1'b0;
    // full final label closed by the end byte
    send_label(MAX_LABEL);
    send_char(dnle_pkg::CH_END);
    // one character too many, then the rest of the name is dropped
    send_label(MAX_LABEL + 1);
    send_label(2);
    send_char(dnle_pkg::CH_DOT);
    send_char(dnle_pkg::CH_END);
  endtask

  task automatic test_name_limit();
    calm = 1'b1;
    // full labels closed by dots up to the limit, then an empty label overflows
    send_long_prefix();
    send_label(MAX_NAME - 3 * (MAX_LABEL + 1) - 1);
    send_char(dnle_pkg::CH_DOT);
    send_char(dnle_pkg::CH_DOT);
    send_label(2);
    send_char(dnle_pkg::CH_END);
    calm = 1'b0;
    // overflow on the end byte, no terminator
    send_long_prefix();
    send_label(MAX_LABEL);
    send_char(dnle_pkg::CH_END);
    send_char(dnle_pkg::CH_END);
  endtask

  task automatic test_random_names();
    int target;
    int labels;
    int len;
    target = chars_sent + RANDOM_ITEMS;
    while (chars_sent < target) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 85) begin
        // well-formed name with random labels
        labels = $urandom_range(0, 5);
        for (int l = 0; l < labels; l++) begin
          if ($urandom_range(0, 99) < 4) len = $urandom_range(MAX_LABEL - 3, MAX_LABEL + 3);
          else len = $urandom_range(0, 10);
          send_label(len);
          if (l < labels - 1 || $urandom_range(0, 2) == 0) send_char(dnle_pkg::CH_DOT);
        end
      end else begin
        // noise: any byte, dots and end bytes included
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 5))
            0:       send_char(dnle_pkg::CH_DOT);
            1:       send_char(dnle_pkg::CH_END);
            default: send_char(dnle_pkg::CHAR_W'($urandom_range(0, 255)));
          endcase
        end
      end
      send_char(dnle_pkg::CH_END);
    end
  endtask

  // Random backpressure on the result side
  always @(negedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall  <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // Compare each accepted beat with the oldest expectation
  always @(posedge clk) begin : check_beat
    wire_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (wire_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected beat: b0=%h b1=%h cnt=%0d sts=%0d last=%b",
                   first_byte, second_byte, byte_count, status, last);
      end else begin
        e = wire_q.pop_front();
        if (first_byte !== e.b0 || second_byte !== e.b1 || byte_count !== e.cnt ||
            status !== e.sts || last !== e.lst) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("beat mismatch: exp b0=%h b1=%h cnt=%0d sts=%0d last=%b, %s",
                     e.b0, e.b1, e.cnt, e.sts, e.lst,
                     $sformatf("got b0=%h b1=%h cnt=%0d sts=%0d last=%b",
                               first_byte, second_byte, byte_count, status, last));
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    char_in    = '0;
    lbl_fill   = 0;
    name_len   = 0;
    discard    = 1'b0;
    calm       = 1'b0;
    chars_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_short_names();
    test_label_limit();
    test_name_limit();
    test_random_names();

    // Drain outstanding beats, then watch for strays
    @(negedge clk);
    in_valid <= 1'b0;
    calm = 1'b0;
    while (wire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
